[sv/assert_macros.svh]
// concurrent assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("%m: invariant violated");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[sv/tmrb_pkg.sv]
`timescale 1ns / 1ps

package tmrb_pkg;

    // bank geometry
    localparam int SLOTS        = 8;
    localparam int SLOT_W       = 3;
    localparam int MAX_CATCH_UP = 6;
    localparam int CU_W         = 3;
    localparam int TIME_W       = 32;

    // action codes
    localparam logic [2:0] ACT_ARM     = 3'd0;
    localparam logic [2:0] ACT_SETIV   = 3'd1;
    localparam logic [2:0] ACT_CLEAR   = 3'd2;
    localparam logic [2:0] ACT_RESTART = 3'd3;
    localparam logic [2:0] ACT_PAUSE   = 3'd4;
    localparam logic [2:0] ACT_TICK    = 3'd5;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    // one slot record as held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] last;
        logic              filt;
        logic [CU_W-1:0]   cu;
    } slot_rec_t;

    // captured input beat
    typedef struct packed {
        logic [2:0]        action;
        logic [SLOT_W-1:0] slot;
        logic              all;
        logic [TIME_W-1:0] period;
        logic              filt;
        logic [CU_W-1:0]   cu;
        logic              pflag;
        logic [TIME_W-1:0] now;
    } item_t;

    // one result beat
    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] time_v;
        logic              status;
        logic              last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_TICK_RD,
        ST_TICK_LOAD,
        ST_TICK_FIRE,
        ST_RESP
    } state_t;

endpackage

[sv/periodic_timer_bank_unit.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel  | dir | tuser            | tdata                                    | tlast
// ---------+-----+------------------+------------------------------------------+------
// s_       | in  | action[2:0]      | slot, all_slots, period, filter_mode,    | -
//          |     |                  | catch_up_limit, pause_flag, now          |
// m_       | out | kind             | fire_slot, fire_time, status             | last
//
// a command is decoded and closed by a status beat; restart or set interval of one slot
// adds a read and write back of that slot, restart of all slots one per slot; a tick
// skips idle and paused slots, reads, checks and writes back the rest, one beat per fire.
// one item is worked at a time; s_tready is high only while the unit is idle.
// aresetn is synchronous, active low, and clears the valid and pause flags at once.
// a stalled m_tready holds the sequencer until the pending result beat is taken.

module periodic_timer_bank_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // slot[2:0], all_slots[3], period[35:4], filter_mode[36],
    // catch_up_limit[39:37], pause_flag[40], now[72:41], zero fill
    input  logic [79:0]            s_tdata,
    // action[2:0]
    input  logic [2:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // fire_slot[2:0], fire_time[34:3], status[35], zero fill
    output logic [39:0]            m_tdata,
    // kind
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import tmrb_pkg::*;

    // state and working registers
    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    slot_rec_t           w_reg, w_next;
    logic [CU_W-1:0]     fcnt_reg, fcnt_next;
    logic                ok_reg, ok_next;
    logic                sweep_reg, sweep_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [SLOTS-1:0]    paused_reg, paused_next;
    result_t             res_reg, res_next;
    logic                m_valid_reg;

    // slot memory
    slot_rec_t           slot_mem [SLOTS];
    slot_rec_t           rdata_reg;
    logic                rd_en;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    slot_rec_t           wr_data;

    logic                res_load;
    logic                out_free;
    logic                in_range;
    logic [TIME_W-1:0]   elapsed;
    logic                behind;
    logic                fire_ok;
    logic [CU_W-1:0]     cu_sat;
    logic                last_idx;

    assign out_free = !m_valid_reg || m_tready;
    assign in_range = {1'b0, item_reg.slot} < (SLOT_W + 1)'(SLOTS);
    assign elapsed  = item_reg.now - w_reg.last;
    assign behind   = elapsed >= w_reg.period;
    // first fire always allowed, further ones only in catch-up mode up to the limit
    assign fire_ok  = (fcnt_reg == '0) || (!w_reg.filt && (fcnt_reg <= w_reg.cu));
    assign cu_sat   = (item_reg.cu > CU_W'(MAX_CATCH_UP)) ? CU_W'(MAX_CATCH_UP) : item_reg.cu;
    assign last_idx = idx_reg == SLOT_W'(SLOTS - 1);

    // memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= slot_mem[idx_reg];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            paused_reg <= '0;
        end else begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            paused_reg <= paused_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        idx_reg   <= idx_next;
        w_reg     <= w_next;
        fcnt_reg  <= fcnt_next;
        ok_reg    <= ok_next;
        sweep_reg <= sweep_next;
    end

    // result output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res_next;
        end
    end

    // sequencer: next state, memory access and result beats
    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        idx_next    = idx_reg;
        w_next      = w_reg;
        fcnt_next   = fcnt_reg;
        ok_next     = ok_reg;
        sweep_next  = sweep_reg;
        valid_next  = valid_reg;
        paused_next = paused_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = w_reg;
        res_load    = 1'b0;
        res_next    = '0;
        s_tready    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    item_next.action = s_tuser;
                    item_next.slot   = s_tdata[2:0];
                    item_next.all    = s_tdata[3];
                    item_next.period = s_tdata[35:4];
                    item_next.filt   = s_tdata[36];
                    item_next.cu     = s_tdata[39:37];
                    item_next.pflag  = s_tdata[40];
                    item_next.now    = s_tdata[72:41];
                    state_next       = ST_DECODE;
                end
            end

            ST_DECODE: begin
                idx_next   = item_reg.slot;
                sweep_next = 1'b0;
                ok_next    = 1'b0;
                state_next = ST_RESP;
                case (item_reg.action)
                    ACT_ARM: begin
                        if (in_range && !valid_reg[item_reg.slot]) begin
                            wr_en          = 1'b1;
                            wr_addr        = item_reg.slot;
                            wr_data.period = item_reg.period;
                            wr_data.last   = item_reg.now;
                            wr_data.filt   = item_reg.filt;
                            wr_data.cu     = cu_sat;
                            valid_next[item_reg.slot]  = 1'b1;
                            paused_next[item_reg.slot] = 1'b0;
                            ok_next        = 1'b1;
                        end
                    end
                    ACT_SETIV: begin
                        if (in_range && valid_reg[item_reg.slot]) begin
                            ok_next    = 1'b1;
                            state_next = ST_RMW_RD;
                        end
                    end
                    ACT_CLEAR: begin
                        if (item_reg.all) begin
                            valid_next = '0;
                            ok_next    = 1'b1;
                        end else if (in_range && valid_reg[item_reg.slot]) begin
                            valid_next[item_reg.slot] = 1'b0;
                            ok_next    = 1'b1;
                        end
                    end
                    ACT_RESTART: begin
                        if (item_reg.all) begin
                            idx_next   = '0;
                            sweep_next = 1'b1;
                            ok_next    = 1'b1;
                            state_next = ST_RMW_RD;
                        end else if (in_range && valid_reg[item_reg.slot]) begin
                            ok_next    = 1'b1;
                            state_next = ST_RMW_RD;
                        end
                    end
                    ACT_PAUSE: begin
                        if (item_reg.all) begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (valid_reg[i]) begin
                                    paused_next[i] = item_reg.pflag;
                                end
                            end
                            ok_next = 1'b1;
                        end else if (in_range && valid_reg[item_reg.slot]) begin
                            paused_next[item_reg.slot] = item_reg.pflag;
                            ok_next = 1'b1;
                        end
                    end
                    ACT_TICK: begin
                        idx_next   = '0;
                        ok_next    = 1'b1;
                        state_next = ST_TICK_RD;
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            // read-modify-write of one slot at a time for set interval and restart
            ST_RMW_RD: begin
                rd_en      = 1'b1;
                state_next = ST_RMW_WR;
            end

            ST_RMW_WR: begin
                wr_data = rdata_reg;
                if (item_reg.action == ACT_SETIV) begin
                    wr_data.period = item_reg.period;
                end else begin
                    wr_data.last = item_reg.now;
                end
                wr_en = valid_reg[idx_reg];
                if (sweep_reg && !last_idx) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RMW_RD;
                end else begin
                    state_next = ST_RESP;
                end
            end

            // tick scan: skip idle and paused slots, read active ones
            ST_TICK_RD: begin
                if (valid_reg[idx_reg] && !paused_reg[idx_reg]) begin
                    rd_en      = 1'b1;
                    state_next = ST_TICK_LOAD;
                end else if (last_idx) begin
                    state_next = ST_RESP;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_TICK_LOAD: begin
                w_next     = rdata_reg;
                fcnt_next  = '0;
                state_next = ST_TICK_FIRE;
            end

            // one fire per free output cycle while behind, then write the slot back
            ST_TICK_FIRE: begin
                if (behind && fire_ok) begin
                    if (out_free) begin
                        res_load        = 1'b1;
                        res_next.kind   = KIND_FIRE;
                        res_next.slot   = idx_reg;
                        res_next.time_v = item_reg.now;
                        fcnt_next       = fcnt_reg + 1'b1;
                        if (w_reg.filt) begin
                            w_next.last = item_reg.now;
                        end else begin
                            w_next.last = w_reg.last + w_reg.period;
                        end
                    end
                end else begin
                    wr_en = 1'b1;
                    if (last_idx) begin
                        state_next = ST_RESP;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_TICK_RD;
                    end
                end
            end

            // status or done beat closes the item
            ST_RESP: begin
                if (out_free) begin
                    res_load        = 1'b1;
                    res_next.kind   = KIND_STATUS;
                    res_next.status = !ok_reg;
                    res_next.last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output ports
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, res_reg.status, res_reg.time_v, res_reg.slot};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

    // checks
    `ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_DECODE)
    `ASSERT_IMPLY(a_fcnt, aclk, aresetn, state_reg == ST_TICK_FIRE, fcnt_reg <= w_reg.cu + 1'b1)
    `ASSERT_IMPLY(a_fire_valid, aclk, aresetn, m_tvalid && m_tuser, valid_reg[m_tdata[2:0]])

endmodule
